// ----- hdl/frqg_pkg.sv -----
// shared types and constants for the frame rate quality governor
`timescale 1ns / 1ps

package frqg_pkg;

    // sliding window geometry
    localparam int WINDOW_DEPTH = 32;
    localparam int HEAD_W       = $clog2(WINDOW_DEPTH);
    localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);
    localparam int RATE_W       = 14;
    localparam int SUM_W        = RATE_W + COUNT_W;
    localparam int BAND_W       = 12;
    localparam int PROD_W       = BAND_W + COUNT_W;

    localparam int TIMER_W      = 16;
    localparam int LEVEL_W      = 3;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 16;

    // quality level codes
    localparam logic [LEVEL_W-1:0] LVL_LOW    = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_MEDIUM = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_HIGH   = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_ULTRA  = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_CUSTOM = 3'd4;

    // item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_RATE  = 2'd1;
    localparam logic [1:0] KIND_FORCE = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_AUTO_ENABLE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_RATE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_COOLDOWN    = 3'd4;

    // register limits and reset values, 4 fractional bits: target Q8.4, threshold Q5.4
    localparam logic [11:0] TARGET_MIN   = 12'd480;
    localparam logic [11:0] TARGET_MAX   = 12'd2304;
    localparam logic [11:0] TARGET_RESET = 12'd960;
    localparam logic [8:0]  THR_MIN      = 9'd16;
    localparam logic [8:0]  THR_MAX      = 9'd480;
    localparam logic [8:0]  THR_RESET    = 9'd80;
    localparam logic [TIMER_W-1:0] INTERVAL_RESET = 16'd100;
    localparam logic [TIMER_W-1:0] COOLDOWN_RESET = 16'd2000;
    localparam logic [TIMER_W-1:0] TIMER_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [1:0]         kind;
        logic [RATE_W-1:0]  frame_rate;
        logic [LEVEL_W-1:0] forced_level;
    } in_word_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               level_changed;
        logic [LEVEL_W-1:0] previous_level;
        logic [15:0]        adjustments;
        logic [5:0]         samples_held;
    } out_word_t;

endpackage

// ----- hdl/frame_rate_quality_governor.sv -----
// frame rate quality governor top level
`timescale 1ns / 1ps

// Takes one word per clock while the output is not stalled and returns one result
// word per input word: an input register, then the window update and level
// decision in one pass into the output register. The window sum is kept
// running, and the oldest sample is prefetched from the sample memory into a
// register, so back-to-back reports are taken at the same rate as other words;
// the two small band multiplies and the sum compare set the clock path.
// Configuration takes effect at the write edge and must happen while idle.
// The sample memory needs no clearing: entries are read only after the window
// has filled.
module frame_rate_quality_governor
    import frqg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_word,
    input  logic                  cfg_write,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic                  auto_enable_reg;
    logic [11:0]           target_reg;
    logic [8:0]            thr_reg;
    logic [BAND_W-1:0]     band_lo_reg;
    logic [BAND_W-1:0]     band_hi_reg;
    logic [TIMER_W-1:0]    interval_reg;
    logic [TIMER_W-1:0]    cooldown_reg;

    // governor state
    logic [LEVEL_W-1:0]    level_reg, level_next;
    logic [HEAD_W-1:0]     head_reg, head_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [TIMER_W-1:0]    tss_reg, tss_next;
    logic [TIMER_W-1:0]    tsa_reg, tsa_next;
    logic [15:0]           adj_reg, adj_next;

    // pipeline
    logic                  in_valid_reg;
    in_word_t              in_word_reg;
    logic                  out_valid_reg;
    out_word_t             out_word_reg, out_word_next;

    // sample memory with prefetched oldest entry
    logic [RATE_W-1:0]     ring [WINDOW_DEPTH];
    logic [RATE_W-1:0]     oldest_reg;
    logic                  push;

    logic                  advance;
    logic                  process;
    logic [11:0]           target_new;
    logic [8:0]            thr_new;
    logic                  clear_window;
    logic [PROD_W-1:0]     lower;
    logic [PROD_W-1:0]     upper;
    logic                  stepped;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;
    assign process  = in_valid_reg && advance;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // register clamping
    always_comb
    begin
        if (cfg_data[11:0] < TARGET_MIN)
            target_new = TARGET_MIN;
        else if (cfg_data[11:0] > TARGET_MAX)
            target_new = TARGET_MAX;
        else
            target_new = cfg_data[11:0];

        if (cfg_data[8:0] < THR_MIN)
            thr_new = THR_MIN;
        else if (cfg_data[8:0] > THR_MAX)
            thr_new = THR_MAX;
        else
            thr_new = cfg_data[8:0];
    end

    assign clear_window = cfg_write && (cfg_addr == REG_AUTO_ENABLE) && cfg_data[0];

    // one pass of the governor over the registered word
    always_comb
    begin
        level_next = level_reg;
        head_next  = head_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        tss_next   = tss_reg;
        tsa_next   = tsa_reg;
        adj_next   = adj_reg;
        push       = 1'b0;
        stepped    = 1'b0;
        lower      = '0;
        upper      = '0;

        if (process)
        begin
            case (in_word_reg.kind)
                KIND_TICK:
                begin
                    if (tss_reg != TIMER_MAX)
                        tss_next = tss_reg + 1'b1;
                    if (tsa_reg != TIMER_MAX)
                        tsa_next = tsa_reg + 1'b1;
                end
                KIND_RATE:
                begin
                    if (auto_enable_reg)
                    begin
                        if (tss_reg >= interval_reg)
                        begin
                            push     = 1'b1;
                            tss_next = '0;
                            // full window drops the oldest sample
                            if (count_reg >= COUNT_W'(WINDOW_DEPTH))
                                sum_next = sum_reg - SUM_W'(oldest_reg)
                                         + SUM_W'(in_word_reg.frame_rate);
                            else
                            begin
                                sum_next   = sum_reg + SUM_W'(in_word_reg.frame_rate);
                                count_next = count_reg + 1'b1;
                            end
                            if (head_reg == HEAD_W'(WINDOW_DEPTH - 1))
                                head_next = '0;
                            else
                                head_next = head_reg + 1'b1;
                        end

                        lower = PROD_W'(band_lo_reg) * PROD_W'(count_next);
                        upper = PROD_W'(band_hi_reg) * PROD_W'(count_next);

                        if (count_next >= COUNT_W'(WINDOW_DEPTH / 2)
                            && tsa_reg >= cooldown_reg)
                        begin
                            if (level_reg != LVL_LOW && sum_next < SUM_W'(lower))
                            begin
                                // custom is left alone
                                if (level_reg != LVL_CUSTOM && level_reg <= LVL_ULTRA)
                                begin
                                    level_next = level_reg - 1'b1;
                                    stepped    = 1'b1;
                                end
                            end
                            else if (level_reg < LVL_ULTRA && sum_next > SUM_W'(upper))
                            begin
                                level_next = level_reg + 1'b1;
                                stepped    = 1'b1;
                            end
                        end

                        if (stepped)
                        begin
                            tsa_next = '0;
                            if (adj_reg != 16'hFFFF)
                                adj_next = adj_reg + 1'b1;
                        end
                    end
                end
                KIND_FORCE:
                begin
                    if (in_word_reg.forced_level <= LVL_CUSTOM)
                        level_next = in_word_reg.forced_level;
                end
                default:
                begin
                    level_next = level_reg;
                end
            endcase
        end

        if (clear_window)
        begin
            head_next  = '0;
            count_next = '0;
            sum_next   = '0;
            tss_next   = '0;
            tsa_next   = '0;
        end

        out_word_next.level          = level_next;
        out_word_next.level_changed  = (level_next != level_reg);
        out_word_next.previous_level = level_reg;
        out_word_next.adjustments    = adj_next;
        out_word_next.samples_held   = 6'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_enable_reg <= 1'b0;
            target_reg      <= TARGET_RESET;
            thr_reg         <= THR_RESET;
            band_lo_reg     <= TARGET_RESET - BAND_W'(THR_RESET);
            band_hi_reg     <= TARGET_RESET + BAND_W'(THR_RESET);
            interval_reg    <= INTERVAL_RESET;
            cooldown_reg    <= COOLDOWN_RESET;
            level_reg       <= LVL_HIGH;
            head_reg        <= '0;
            count_reg       <= '0;
            sum_reg         <= '0;
            tss_reg         <= '0;
            tsa_reg         <= '0;
            adj_reg         <= '0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_addr)
                    REG_AUTO_ENABLE: auto_enable_reg <= cfg_data[0];
                    REG_TARGET_RATE:
                    begin
                        target_reg  <= target_new;
                        band_lo_reg <= target_new - BAND_W'(thr_reg);
                        band_hi_reg <= target_new + BAND_W'(thr_reg);
                    end
                    REG_THRESHOLD:
                    begin
                        thr_reg     <= thr_new;
                        band_lo_reg <= target_reg - BAND_W'(thr_new);
                        band_hi_reg <= target_reg + BAND_W'(thr_new);
                    end
                    REG_INTERVAL:    interval_reg <= cfg_data;
                    REG_COOLDOWN:    cooldown_reg <= cfg_data;
                    default:         auto_enable_reg <= auto_enable_reg;
                endcase
            end

            level_reg <= level_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            tss_reg   <= tss_next;
            tsa_reg   <= tsa_next;
            adj_reg   <= adj_next;

            if (in_ready)
                in_valid_reg <= in_valid;

            if (process)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready)
            in_word_reg <= in_word;
        if (process)
            out_word_reg <= out_word_next;
    end

    // sample memory: write at head, keep the entry at the next head ready
    always_ff @(posedge clk)
    begin
        if (push)
            ring[head_reg] <= in_word_reg.frame_rate;
        oldest_reg <= ring[head_next];
    end

endmodule

// ----- tb/frqg_checker.sv -----
// scoreboard for the frame rate quality governor: predicts each result word and compares
`timescale 1ns / 1ps

module frqg_checker
    import frqg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_word_t              in_word,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_word_t             out_word,
    input  logic                  cfg_write,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    // shadow registers
    logic               auto_on;
    logic [11:0]        target;
    logic [8:0]         band;
    logic [TIMER_W-1:0] interval;
    logic [TIMER_W-1:0] cooldown;

    // shadow governor state
    logic [LEVEL_W-1:0] level_q;
    logic [RATE_W-1:0]  ring [WINDOW_DEPTH];
    int                 head;
    int                 count;
    int                 sum;
    logic [TIMER_W-1:0] since_sample;
    logic [TIMER_W-1:0] since_adjust;
    logic [15:0]        adj_count;

    out_word_t          level_reports_q[$];

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == TIMER_MAX) ? v : v + 16'd1;
    endfunction

    task automatic clear_window();
        head         = 0;
        count        = 0;
        sum          = 0;
        since_sample = '0;
        since_adjust = '0;
    endtask

    task automatic apply_write(input logic [CFG_ADDR_W-1:0] addr,
                               input logic [CFG_DATA_W-1:0] data);
        logic [11:0] t;
        logic [8:0]  b;
        t = data[11:0];
        b = data[8:0];
        case (addr)
            REG_AUTO_ENABLE:
            begin
                auto_on = data[0];
                if (data[0])
                    clear_window();
            end
            REG_TARGET_RATE: target = (t < TARGET_MIN) ? TARGET_MIN :
                                      (t > TARGET_MAX) ? TARGET_MAX : t;
            REG_THRESHOLD:   band = (b < THR_MIN) ? THR_MIN : (b > THR_MAX) ? THR_MAX : b;
            REG_INTERVAL:    interval = data;
            REG_COOLDOWN:    cooldown = data;
            default: ;
        endcase
    endtask

    task automatic push_rate(input logic [RATE_W-1:0] rate);
        if (count >= WINDOW_DEPTH)
            sum = sum - int'(ring[head]);
        else
            count++;
        ring[head] = rate;
        sum = sum + int'(rate);
        head = (head + 1 >= WINDOW_DEPTH) ? 0 : head + 1;
    endtask

    // band compare against the window average, scaled by count to stay exact
    task automatic level_decision();
        int   lower;
        int   upper;
        logic stepped;
        stepped = 1'b0;
        if (count < WINDOW_DEPTH / 2)
            return;
        if (since_adjust < cooldown)
            return;
        lower = (int'(target) - int'(band)) * count;
        upper = (int'(target) + int'(band)) * count;
        if (level_q != LVL_LOW && sum < lower)
        begin
            if (level_q != LVL_CUSTOM && level_q <= LVL_ULTRA)
            begin
                level_q = level_q - 3'd1;
                stepped = 1'b1;
            end
        end
        else if (level_q < LVL_ULTRA && sum > upper)
        begin
            level_q = level_q + 3'd1;
            stepped = 1'b1;
        end
        if (stepped)
        begin
            since_adjust = '0;
            adj_count    = sat_inc(adj_count);
        end
    endtask

    task automatic govern(input in_word_t w, output out_word_t r);
        logic [LEVEL_W-1:0] prev;
        prev = level_q;
        case (w.kind)
            KIND_TICK:
            begin
                since_sample = sat_inc(since_sample);
                since_adjust = sat_inc(since_adjust);
            end
            KIND_RATE:
            begin
                if (auto_on)
                begin
                    if (since_sample >= interval)
                    begin
                        push_rate(w.frame_rate);
                        since_sample = '0;
                    end
                    level_decision();
                end
            end
            KIND_FORCE:
            begin
                if (w.forced_level <= LVL_CUSTOM)
                    level_q = w.forced_level;
            end
            default: ;
        endcase
        r.level          = level_q;
        r.level_changed  = (level_q != prev);
        r.previous_level = prev;
        r.adjustments    = adj_count;
        r.samples_held   = 6'(count);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t w;
        if (!rst_n)
        begin
            auto_on   = 1'b0;
            target    = TARGET_RESET;
            band      = THR_RESET;
            interval  = INTERVAL_RESET;
            cooldown  = COOLDOWN_RESET;
            level_q   = LVL_HIGH;
            adj_count = '0;
            clear_window();
            level_reports_q.delete();
            errors  = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
                apply_write(cfg_addr, cfg_data);
            if (in_valid && in_ready)
            begin
                govern(in_word, w);
                level_reports_q.insert(level_reports_q.size(), w);
            end
            if (out_valid && out_ready)
            begin
                if (level_reports_q.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected word, expected none, actual %p", $time, out_word);
                end
                else
                begin
                    w = level_reports_q.pop_front();
                    compare_field("level", int'(w.level), int'(out_word.level));
                    compare_field("level_changed", int'(w.level_changed),
                                  int'(out_word.level_changed));
                    compare_field("previous_level", int'(w.previous_level),
                                  int'(out_word.previous_level));
                    compare_field("adjustments", int'(w.adjustments),
                                  int'(out_word.adjustments));
                    compare_field("samples_held", int'(w.samples_held),
                                  int'(out_word.samples_held));
                end
            end
            pending <= level_reports_q.size();
        end
    end

endmodule

// ----- tb/frame_rate_quality_governor_tb.sv -----
// testbench top for the frame rate quality governor: stimulus, idling and verdict
`timescale 1ns / 1ps

module frame_rate_quality_governor_tb;
    import frqg_pkg::*;

    localparam int LIMIT       = 1_000_000;
    localparam int N_PHASES    = 8;
    localparam int PHASE_WORDS = 50;
    localparam int HOLD_CYCLES = 300;
    localparam int GAP_TICKS   = 16;

    localparam logic [1:0]         KIND_UNUSED = 2'd3;
    localparam logic [LEVEL_W-1:0] LVL_BAD_LO  = 3'd5;
    localparam logic [LEVEL_W-1:0] LVL_BAD_HI  = 3'd7;
    localparam logic [RATE_W-1:0]  RATE_TOP    = 14'h3FFF;

    // rate bias relative to the hysteresis band
    localparam int BIAS_LOW  = 0;
    localparam int BIAS_HIGH = 1;
    localparam int BIAS_MID  = 2;

    // per-phase register settings, -1 picks a random legal value
    localparam int PH_TARGET   [N_PHASES] = '{960, 480, 2304, 0, 4095, -1, -1, 1200};
    localparam int PH_BAND     [N_PHASES] = '{80, 16, 480, 0, 511, -1, -1, 100};
    localparam int PH_INTERVAL [N_PHASES] = '{0, 1, 0, 2, 0, -1, 0, 0};
    localparam int PH_COOLDOWN [N_PHASES] = '{0, 3, 10, 0, 5, -1, 0, 2};
    // 0 disable, 1 enable, 2 leave the window alone
    localparam int PH_AUTO     [N_PHASES] = '{1, 1, 2, 1, 1, 1, 0, 1};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_word_t              in_word   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_word_t             out_word;
    logic                  cfg_write = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int   fail_count;
    int   pending;
    int   cycles         = 0;
    int   sent           = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic rx_hold        = 1'b0;
    int   eff_target     = 960;
    int   eff_band       = 80;

    always #2 clk = ~clk;

    frame_rate_quality_governor u_top (.*);

    frqg_checker u_check (.*, .errors(fail_count));

    always @(posedge clk)
        out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
            $display("frame_rate_quality_governor_tb failed");
            $finish;
        end
    end

    function automatic in_word_t make_word(input logic [1:0] k, input logic [RATE_W-1:0] r,
                                           input logic [LEVEL_W-1:0] l);
        in_word_t w;
        w.kind         = k;
        w.frame_rate   = r;
        w.forced_level = l;
        return w;
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate(input int bias);
        int v;
        case (bias)
            BIAS_LOW:  v = eff_target - eff_band - int'($urandom_range(1, 160));
            BIAS_HIGH: v = eff_target + eff_band + int'($urandom_range(1, 160));
            default:   v = eff_target - eff_band + int'($urandom_range(0, 2 * eff_band));
        endcase
        if (v < 0)
            v = 0;
        return RATE_W'(v);
    endfunction

    // valid stays up across back-to-back words, dropped only for a gap
    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input int d);
        cfg_write <= 1'b1;
        cfg_addr  <= a;
        cfg_data  <= CFG_DATA_W'(d);
        @(posedge clk);
    endtask

    task automatic configure(input int t, input int b, input int iv, input int cd,
                             input int auto_mode);
        write_reg(REG_TARGET_RATE, t);
        write_reg(REG_THRESHOLD, b);
        write_reg(REG_INTERVAL, iv);
        write_reg(REG_COOLDOWN, cd);
        if (auto_mode != 2)
            write_reg(REG_AUTO_ENABLE, auto_mode);
        cfg_write <= 1'b0;
        t = t & 12'hFFF;
        b = b & 9'h1FF;
        eff_target = (t < TARGET_MIN) ? TARGET_MIN : (t > TARGET_MAX) ? TARGET_MAX : t;
        eff_band   = (b < THR_MIN) ? THR_MIN : (b > THR_MAX) ? THR_MAX : b;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct   = 0;
                recv_stall_pct <= 0;
            end
            1:
            begin
                send_idle_pct   = 61;
                recv_stall_pct <= 0;
            end
            2:
            begin
                send_idle_pct   = 0;
                recv_stall_pct <= 61;
            end
            default:
            begin
                send_idle_pct   = 18;
                recv_stall_pct <= 18;
            end
        endcase
    endtask

    task automatic random_words(input int n);
        in_word_t w;
        int       r;
        int       bias;
        bias = BIAS_MID;
        for (int i = 0; i < n; i++)
        begin
            if (i % 15 == 0)
                bias = $urandom_range(BIAS_LOW, BIAS_MID);
            w.frame_rate   = RATE_W'($urandom_range(0, RATE_TOP));
            w.forced_level = LEVEL_W'($urandom_range(0, 7));
            r = $urandom_range(99);
            if (r < 60)
            begin
                w.kind = KIND_RATE;
                if ($urandom_range(99) < 85)
                    w.frame_rate = pick_rate(bias);
            end
            else if (r < 88)
                w.kind = KIND_TICK;
            else if (r < 97)
                w.kind = KIND_FORCE;
            else
                w.kind = KIND_UNUSED;
            send_word(w);
        end
    endtask

    initial
    begin
        int t;
        int b;
        int iv;
        int cd;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // governor off: reports ignored, forced levels including illegal ones
        send_word(make_word(KIND_TICK, '0, '0));
        send_word(make_word(KIND_RATE, RATE_TOP, LVL_BAD_HI));
        send_word(make_word(KIND_RATE, '0, '0));
        send_word(make_word(KIND_FORCE, '0, LVL_LOW));
        send_word(make_word(KIND_FORCE, RATE_TOP, LVL_MEDIUM));
        send_word(make_word(KIND_FORCE, '0, LVL_HIGH));
        send_word(make_word(KIND_FORCE, '0, LVL_ULTRA));
        send_word(make_word(KIND_FORCE, '0, LVL_CUSTOM));
        send_word(make_word(KIND_FORCE, '0, LVL_CUSTOM));
        send_word(make_word(KIND_FORCE, '0, LVL_BAD_LO));
        send_word(make_word(KIND_FORCE, '0, LVL_BAD_HI));
        send_word(make_word(KIND_UNUSED, RATE_TOP, LVL_BAD_HI));
        send_word(make_word(KIND_FORCE, '0, LVL_ULTRA));
        drain();

        // fill past half a window with low rates, then reports come too early to count
        configure(960, 80, 0, 0, 1);
        for (int i = 0; i < 20; i++)
            send_word(make_word(KIND_RATE, pick_rate(BIAS_LOW), '0));
        drain();
        configure(960, 80, 16'hFFFF, 16'hFFFF, 2);
        send_word(make_word(KIND_FORCE, '0, LVL_ULTRA));
        for (int i = 0; i < GAP_TICKS; i++)
            send_word(make_word(KIND_TICK, '0, '0));
        send_word(make_word(KIND_RATE, pick_rate(BIAS_LOW), '0));
        send_word(make_word(KIND_RATE, pick_rate(BIAS_LOW), '0));
        send_word(make_word(KIND_TICK, '0, '0));

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain();
            t  = (PH_TARGET[p] < 0) ? int'($urandom_range(480, 2304)) : PH_TARGET[p];
            b  = (PH_BAND[p] < 0) ? int'($urandom_range(16, 480)) : PH_BAND[p];
            iv = (PH_INTERVAL[p] < 0) ? int'($urandom_range(0, 3)) : PH_INTERVAL[p];
            cd = (PH_COOLDOWN[p] < 0) ? int'($urandom_range(0, 20)) : PH_COOLDOWN[p];
            configure(t, b, iv, cd, PH_AUTO[p]);
            set_idling(p % 4);
            if (p == 0)
            begin
                // long output stall while words keep coming, so the input backs up
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        rx_hold <= 1'b0;
                    end
                    random_words(PHASE_WORDS);
                join
            end
            else
                random_words(PHASE_WORDS);
        end

        drain();
        repeat (8) @(posedge clk);
        $display("covered %0d words: illegal and forced levels, reports held off by long",
                 sent);
        $display("interval and cooldown, %0d register settings with idling and a %0d-cycle stall",
                 N_PHASES + 2, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("frame_rate_quality_governor_tb passed");
        else
            $display("frame_rate_quality_governor_tb failed");
        $finish;
    end

endmodule
